FILE: design/skt_pkg.sv
package skt_pkg;

    // widths fixed by the request and result formats
    localparam int KEY_W   = 64;
    localparam int PAY_W   = 16;
    localparam int POS_W   = 5;
    localparam int TOTAL_W = 6;

    // defaults for the top level parameters
    localparam int CAPACITY_DEF = 32;
    localparam int KEY_BITS_DEF = 64;

    // request codes
    localparam logic [1:0] REQ_FIND   = 2'd0;
    localparam logic [1:0] REQ_ADD    = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // request wave travelling down the cell chain
    typedef struct packed {
        logic             valid;
        logic [1:0]       req;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] pay;
        logic             done;      // a cell has settled the outcome
        logic             shifting;  // entries move from here on
        logic [1:0]       status;
        logic [POS_W-1:0] pos;
        logic [PAY_W-1:0] fpay;
        logic [KEY_W-1:0] carry_key; // entry pushed up by an add
        logic [PAY_W-1:0] carry_pay;
    } wave_t;

endpackage

FILE: design/sorted_key_table_top.sv
// Sorted key table: holds up to CAPACITY unique keys in ascending unsigned order, each with a
// 16-bit payload handle, in a row of CAPACITY cells. A request (find, add or remove) travels
// down the row one cell per cycle; the first cell whose key is not below the request key
// settles it, and for a successful add or remove every later cell swaps with or pulls from its
// neighbor as the request passes, so the table stays sorted. A request passes from the launch
// register, which loads at the accepting edge, through the register of each cell in turn and
// into the output register. The next request is taken as soon as the previous result has
// moved into the output register, so requests never overlap in the cell row. Only the low
// KEY_BITS bits of the key take part. An add of a present key answers already present even
// when the table is full. A find on an empty slot is never answered from stale cell contents,
// since only cells below the entry count are compared.
module sorted_key_table_top
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // key [63:0], payload [79:64]
    input  logic [1:0]  s_tuser,   // req_type [1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // position [4:0], found_payload [20:5], entry_total [26:21]
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int COUNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } state_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [POS_W-1:0]   pos;
        logic [PAY_W-1:0]   fpay;
        logic [TOTAL_W-1:0] total;
    } res_t;

    state_t              state_reg;
    wave_t               launch_reg;
    logic [COUNT_W-1:0]  count_reg, count_next;
    res_t                hold_reg;
    res_t                out_reg;
    logic                m_tvalid_reg;

    // cell row wiring
    wave_t               wave_chain [CAPACITY+1];
    logic [KEY_BITS-1:0] cell_key   [CAPACITY];
    logic [PAY_W-1:0]    cell_pay   [CAPACITY];

    wave_t               last_wave;
    res_t                fin_res;
    logic                req_take;
    logic                out_free;
    logic                out_load;

    assign wave_chain[0] = launch_reg;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_BITS-1:0] nb_key;
        logic [PAY_W-1:0]    nb_pay;
        if (i == CAPACITY - 1) begin : g_end
            // no neighbor above the last cell: it keeps its own entry
            assign nb_key = cell_key[i];
            assign nb_pay = cell_pay[i];
        end else begin : g_mid
            assign nb_key = cell_key[i+1];
            assign nb_pay = cell_pay[i+1];
        end
        skt_cell #(
            .KEY_BITS (KEY_BITS),
            .CAPACITY (CAPACITY),
            .COUNT_W  (COUNT_W),
            .INDEX    (i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .count_i  (count_reg),
            .wave_i   (wave_chain[i]),
            .nb_key_i (nb_key),
            .nb_pay_i (nb_pay),
            .wave_o   (wave_chain[i+1]),
            .key_o    (cell_key[i]),
            .pay_o    (cell_pay[i])
        );
    end

    assign last_wave = wave_chain[CAPACITY];
    assign s_tready  = (state_reg == S_IDLE);
    assign req_take  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    // a result moves into the output register this cycle
    assign out_load  = out_free && ((state_reg == S_RUN && last_wave.valid)
                                    || state_reg == S_HOLD);

    // settle the result once the request leaves the last cell
    always_comb begin
        fin_res.pos  = last_wave.pos;
        fin_res.fpay = last_wave.fpay;
        if (last_wave.done) begin
            fin_res.status = last_wave.status;
        end else if (last_wave.req == REQ_ADD) begin
            // every held key below the new one and no free cell
            fin_res.status = ST_FULL;
        end else begin
            fin_res.status = ST_NOT_FOUND;
        end
        count_next = count_reg;
        if (fin_res.status == ST_OK && last_wave.req == REQ_ADD) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (fin_res.status == ST_OK && last_wave.req == REQ_REMOVE) begin
            count_next = count_reg - COUNT_W'(1);
        end
        fin_res.total = TOTAL_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            m_tvalid_reg     <= 1'b0;
            launch_reg.valid <= 1'b0;
        end else begin
            launch_reg.valid <= req_take;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (req_take) begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (last_wave.valid) begin
                        count_reg <= count_next;
                        if (out_free) begin
                            out_reg   <= fin_res;
                            state_reg <= S_IDLE;
                        end else begin
                            hold_reg  <= fin_res;
                            state_reg <= S_HOLD;
                        end
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        out_reg   <= hold_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
        // request payload, taken with the request
        if (req_take) begin
            launch_reg.req       <= s_tuser;
            launch_reg.key       <= KEY_W'(s_tdata[KEY_BITS-1:0]);
            launch_reg.pay       <= s_tdata[79:64];
            launch_reg.done      <= 1'b0;
            launch_reg.shifting  <= 1'b0;
            launch_reg.status    <= ST_NOT_FOUND;
            launch_reg.pos       <= '0;
            launch_reg.fpay      <= '0;
            launch_reg.carry_key <= '0;
            launch_reg.carry_pay <= '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {5'd0, out_reg.total, out_reg.fpay, out_reg.pos};

    // a request leaving the cell row means the block is busy
    a_row_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        last_wave.valid |-> state_reg == S_RUN)
        else $error("request left the cell row while not running");

    // a failed request reports no position and no payload
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[4:0] == 5'd0 && m_tdata[20:5] == 16'd0))
        else $error("failed request carries position or payload");

    // full is only reported at capacity
    a_full_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN && last_wave.valid && fin_res.status == ST_FULL)
            |-> count_reg == COUNT_W'(CAPACITY))
        else $error("table full reported below capacity");

    // entry count changes only when a request leaves the cell row, by at most one
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !last_wave.valid |=> count_reg == $past(count_reg))
        else $error("entry count changed without a finishing request");

endmodule

FILE: design/skt_cell.sv
module skt_cell
    import skt_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int COUNT_W  = 6,
    parameter int INDEX    = 0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [COUNT_W-1:0]  count_i,
    input  wave_t               wave_i,
    input  logic [KEY_BITS-1:0] nb_key_i,
    input  logic [PAY_W-1:0]    nb_pay_i,
    output wave_t               wave_o,
    output logic [KEY_BITS-1:0] key_o,
    output logic [PAY_W-1:0]    pay_o
);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PAY_W-1:0]    pay_reg, pay_next;
    wave_t               wave_reg, wave_next;
    logic                occupied;
    logic                less;
    logic                eq;

    always_comb begin
        occupied  = COUNT_W'(INDEX) < count_i;
        less      = occupied && (key_reg < wave_i.key[KEY_BITS-1:0]);
        eq        = occupied && (key_reg == wave_i.key[KEY_BITS-1:0]);
        wave_next = wave_i;
        key_next  = key_reg;
        pay_next  = pay_reg;
        if (wave_i.valid) begin
            if (wave_i.shifting) begin
                if (wave_i.req == REQ_ADD) begin
                    // swap with the entry carried from below
                    key_next            = wave_i.carry_key[KEY_BITS-1:0];
                    pay_next            = wave_i.carry_pay;
                    wave_next.carry_key = KEY_W'(key_reg);
                    wave_next.carry_pay = pay_reg;
                end else begin
                    key_next = nb_key_i;
                    pay_next = nb_pay_i;
                end
            end else if (!wave_i.done && !less) begin
                // first cell not below the key settles the request
                case (wave_i.req)
                    REQ_FIND: begin
                        wave_next.done = 1'b1;
                        if (eq) begin
                            wave_next.status = ST_OK;
                            wave_next.pos    = POS_W'(INDEX);
                            wave_next.fpay   = pay_reg;
                        end else begin
                            wave_next.status = ST_NOT_FOUND;
                        end
                    end
                    REQ_ADD: begin
                        wave_next.done = 1'b1;
                        if (eq) begin
                            wave_next.status = ST_PRESENT;
                        end else if (count_i == COUNT_W'(CAPACITY)) begin
                            // absent key but no room left
                            wave_next.status = ST_FULL;
                        end else begin
                            wave_next.status    = ST_OK;
                            wave_next.pos       = POS_W'(INDEX);
                            wave_next.shifting  = 1'b1;
                            wave_next.carry_key = KEY_W'(key_reg);
                            wave_next.carry_pay = pay_reg;
                            key_next            = wave_i.key[KEY_BITS-1:0];
                            pay_next            = wave_i.pay;
                        end
                    end
                    REQ_REMOVE: begin
                        wave_next.done = 1'b1;
                        if (eq) begin
                            wave_next.status   = ST_OK;
                            wave_next.pos      = POS_W'(INDEX);
                            wave_next.shifting = 1'b1;
                            key_next           = nb_key_i;
                            pay_next           = nb_pay_i;
                        end else begin
                            wave_next.status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg <= '0;
        end else begin
            wave_reg <= wave_next;
        end
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign wave_o = wave_reg;
    assign key_o  = key_reg;
    assign pay_o  = pay_reg;

endmodule
